### rtl/pawr_pkg.sv
// Shared types and constants of the pixel alpha blend writer.
package pawr_pkg;

   // Field widths of the channels.
   localparam int ChanWidth     = 8;
   localparam int PosWidth      = 16;
   localparam int AddrWidth     = 26;
   localparam int RegWidth      = 13;
   localparam int CsrIndexWidth = 8;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] REG_FRAME_WIDTH  = 8'd0;
   localparam logic [CsrIndexWidth-1:0] REG_FRAME_HEIGHT = 8'd1;

   // Register reset values.
   localparam logic [RegWidth-1:0] FrameWidthReset  = 13'd640;
   localparam logic [RegWidth-1:0] FrameHeightReset = 13'd480;

   // Request modes: write a pixel, or arm a discard of the next write.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_ARM   = 1'b1;

   // Full scale of an 8-bit color value.
   localparam logic [ChanWidth-1:0] FullScale = 8'd255;

   // Channel codes, also the order in which the blend visits them.
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   // The quotient has eight bits, one per divider step.
   localparam logic [2:0] DivLastStep = 3'd7;

   // Sequencer states.
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_ADDR   = 8'b0000_0010,
      ST_KA     = 8'b0000_0100,
      ST_KD     = 8'b0000_1000,
      ST_NUM_S  = 8'b0001_0000,
      ST_NUM_D  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

endpackage

### rtl/pawr_channels.sv
// Handshake channel interfaces of the pixel alpha blend writer.
interface pawr_req_if;
   import pawr_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic signed [PosWidth-1:0]  pos_x;
   logic signed [PosWidth-1:0]  pos_y;
   logic [ChanWidth-1:0]        src_red;
   logic [ChanWidth-1:0]        src_green;
   logic [ChanWidth-1:0]        src_blue;
   logic [ChanWidth-1:0]        src_alpha;
   logic                        blend_enable;
   logic [ChanWidth-1:0]        dst_red;
   logic [ChanWidth-1:0]        dst_green;
   logic [ChanWidth-1:0]        dst_blue;
   logic [ChanWidth-1:0]        dst_alpha;

   modport source (
      output valid, mode, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
             blend_enable, dst_red, dst_green, dst_blue, dst_alpha,
      input  ready
   );
   modport sink (
      input  valid, mode, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
             blend_enable, dst_red, dst_green, dst_blue, dst_alpha,
      output ready
   );
endinterface

interface pawr_rsp_if;
   import pawr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  write_enable;
   logic [AddrWidth-1:0]  byte_address;
   logic [ChanWidth-1:0]  out_byte0_blue;
   logic [ChanWidth-1:0]  out_byte1_green;
   logic [ChanWidth-1:0]  out_byte2_red;
   logic [ChanWidth-1:0]  out_byte3_alpha;
   logic                  was_discarded;

   modport source (
      output valid, write_enable, byte_address, out_byte0_blue, out_byte1_green,
             out_byte2_red, out_byte3_alpha, was_discarded,
      input  ready
   );
   modport sink (
      input  valid, write_enable, byte_address, out_byte0_blue, out_byte1_green,
             out_byte2_red, out_byte3_alpha, was_discarded,
      output ready
   );
endinterface

interface pawr_csr_if;
   import pawr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CsrIndexWidth-1:0]  index;
   logic [RegWidth-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/pixel_alpha_blend_writer.sv
// Top level of the pixel alpha blend writer: bounds check, address and blend sequencer.
//
// Each request transfer is handled alone by a small sequencer around one shared
// 13 x 16 multiplier and an 8-step restoring divider. A blended in-range write
// keeps the request side busy through the transfer, the address multiply, the two
// alpha weights, two multiplies and eight divider steps for each of the four
// channels, and the finish state. When both alphas are zero the divider is
// skipped. An overwrite goes through the address multiply to the finish state,
// and an arm, a discarded write or an out-of-range position straight to the
// finish state. The finished result sits in an output register, so the next
// request is taken while it waits; the sequencer only holds in its finish state
// when that register is still full. Configuration writes are taken in any cycle;
// one also reaches a request in flight whose address is not yet formed.
module pixel_alpha_blend_writer #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   pawr_req_if.sink    req_bus,
   pawr_rsp_if.source  rsp_bus,
   pawr_csr_if.sink    csr_bus
);
   import pawr_pkg::*;

   localparam logic [14:0] MaxWidthC  = 15'(MAX_WIDTH);
   localparam logic [14:0] MaxHeightC = 15'(MAX_HEIGHT);

   // Control state.
   state_type            state_ff, state_in;
   logic                 pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RegWidth-1:0]  width_ff, width_in;
   logic [RegWidth-1:0]  height_ff, height_in;
   logic [1:0]           ch_ff, ch_in;
   logic [2:0]           step_ff, step_in;

   // Item payload and working registers.
   logic [ChanWidth-1:0] src_ff [4];
   logic [ChanWidth-1:0] src_in [4];
   logic [ChanWidth-1:0] dst_ff [4];
   logic [ChanWidth-1:0] dst_in [4];
   logic [12:0]          x_ff, x_in;
   logic [12:0]          y_ff, y_in;
   logic                 blend_ff, blend_in;
   logic                 we_ff, we_in;
   logic                 disc_ff, disc_in;
   logic [23:0]          pix_ff, pix_in;
   logic [15:0]          ka_ff, ka_in;
   logic [15:0]          kd_ff, kd_in;
   logic [16:0]          den_ff, den_in;
   logic [23:0]          acc_ff, acc_in;
   logic [23:0]          rem_ff, rem_in;
   logic [23:0]          dsh_ff, dsh_in;
   logic [7:0]           q_ff, q_in;

   // Output register.
   logic                 o_we_ff, o_we_in;
   logic [AddrWidth-1:0] o_addr_ff, o_addr_in;
   logic [ChanWidth-1:0] o_blue_ff, o_blue_in;
   logic [ChanWidth-1:0] o_green_ff, o_green_in;
   logic [ChanWidth-1:0] o_red_ff, o_red_in;
   logic [ChanWidth-1:0] o_alpha_ff, o_alpha_in;
   logic                 o_disc_ff, o_disc_in;

   // Shared multiplier and helpers.
   logic [12:0]          mul_a;
   logic [15:0]          mul_b;
   logic [28:0]          prod;
   logic [RegWidth-1:0]  width_eff;
   logic [RegWidth-1:0]  height_eff;
   logic                 req_xfer;
   logic                 out_of_range;
   logic                 div_ge;
   logic [7:0]           q_next;
   logic                 out_free;

   assign prod = {16'b0, mul_a} * {13'b0, mul_b};

   // Frame size limited to the largest supported frame.
   assign width_eff  = ({2'b0, width_ff} > MaxWidthC) ? MaxWidthC[12:0] : width_ff;
   assign height_eff = ({2'b0, height_ff} > MaxHeightC) ? MaxHeightC[12:0] : height_ff;

   // Handshakes.
   assign req_bus.ready = state_ff == ST_IDLE;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Bounds check of the incoming position.
   assign out_of_range = req_bus.pos_x[PosWidth-1] || req_bus.pos_y[PosWidth-1]
      || ({1'b0, req_bus.pos_x[14:0]} >= {3'b0, width_eff})
      || ({1'b0, req_bus.pos_y[14:0]} >= {3'b0, height_eff});

   // One restoring divider step.
   assign div_ge = rem_ff >= dsh_ff;
   assign q_next = {q_ff[6:0], div_ge};

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_FRAME_WIDTH:  width_in  = csr_bus.data;
            REG_FRAME_HEIGHT: height_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      ch_in        = ch_ff;
      step_in      = step_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      blend_in     = blend_ff;
      we_in        = we_ff;
      disc_in      = disc_ff;
      pix_in       = pix_ff;
      ka_in        = ka_ff;
      kd_in        = kd_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      mul_a        = '0;
      mul_b        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      o_we_in      = o_we_ff;
      o_addr_in    = o_addr_ff;
      o_blue_in    = o_blue_ff;
      o_green_in   = o_green_ff;
      o_red_in     = o_red_ff;
      o_alpha_in   = o_alpha_ff;
      o_disc_in    = o_disc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               src_in[CH_RED]   = req_bus.src_red;
               src_in[CH_GREEN] = req_bus.src_green;
               src_in[CH_BLUE]  = req_bus.src_blue;
               src_in[CH_ALPHA] = req_bus.src_alpha;
               dst_in[CH_RED]   = req_bus.dst_red;
               dst_in[CH_GREEN] = req_bus.dst_green;
               dst_in[CH_BLUE]  = req_bus.dst_blue;
               dst_in[CH_ALPHA] = req_bus.dst_alpha;
               x_in     = req_bus.pos_x[12:0];
               y_in     = req_bus.pos_y[12:0];
               blend_in = req_bus.blend_enable;
               we_in    = 1'b0;
               disc_in  = 1'b0;
               state_in = ST_FINISH;
               if (req_bus.mode == MODE_ARM) begin
                  pend_in = 1'b1;
               end else if (pend_ff) begin
                  pend_in = 1'b0;
                  disc_in = 1'b1;
               end else if (!out_of_range) begin
                  we_in    = 1'b1;
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            // Pixel index y*width + x; the byte address keeps its low bits.
            mul_a    = width_eff;
            mul_b    = {3'b0, y_ff};
            pix_in   = prod[23:0] + {11'b0, x_ff};
            state_in = blend_ff ? ST_KA : ST_FINISH;
         end
         ST_KA: begin
            // Source weight sa*255.
            mul_a    = {5'b0, src_ff[CH_ALPHA]};
            mul_b    = {8'b0, FullScale};
            ka_in    = prod[15:0];
            state_in = ST_KD;
         end
         ST_KD: begin
            // Destination weight da*(255-sa) and the common denominator.
            mul_a    = {5'b0, dst_ff[CH_ALPHA]};
            mul_b    = {8'b0, FullScale - src_ff[CH_ALPHA]};
            kd_in    = prod[15:0];
            den_in   = {1'b0, ka_ff} + {1'b0, prod[15:0]};
            ch_in    = CH_RED;
            state_in = ST_NUM_S;
         end
         ST_NUM_S: begin
            mul_a    = {5'b0, src_ff[ch_ff]};
            mul_b    = ka_ff;
            acc_in   = prod[23:0];
            state_in = ST_NUM_D;
         end
         ST_NUM_D: begin
            mul_a   = {5'b0, dst_ff[ch_ff]};
            mul_b   = kd_ff;
            rem_in  = acc_ff + prod[23:0];
            dsh_in  = {den_ff, 7'b0};
            q_in    = '0;
            step_in = '0;
            if (den_ff == '0) begin
               // Both alphas zero: the channel is black and transparent.
               src_in[ch_ff] = '0;
               if (ch_ff == CH_ALPHA) begin
                  state_in = ST_FINISH;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_NUM_S;
               end
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            q_in    = q_next;
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 3'd1;
            if (step_ff == DivLastStep) begin
               src_in[ch_ff] = q_next;
               if (ch_ff == CH_ALPHA) begin
                  state_in = ST_FINISH;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_NUM_S;
               end
            end
         end
         ST_FINISH: begin
            // Load the output register once it is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_we_in      = we_ff;
               o_disc_in    = disc_ff;
               o_addr_in    = we_ff ? {pix_ff, 2'b00} : '0;
               o_blue_in    = we_ff ? src_ff[CH_BLUE] : '0;
               o_green_in   = we_ff ? src_ff[CH_GREEN] : '0;
               o_red_in     = we_ff ? src_ff[CH_RED] : '0;
               o_alpha_in   = we_ff ? src_ff[CH_ALPHA] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= FrameWidthReset;
         height_ff    <= FrameHeightReset;
         ch_ff        <= CH_RED;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      blend_ff   <= blend_in;
      we_ff      <= we_in;
      disc_ff    <= disc_in;
      pix_ff     <= pix_in;
      ka_ff      <= ka_in;
      kd_ff      <= kd_in;
      den_ff     <= den_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      q_ff       <= q_in;
      o_we_ff    <= o_we_in;
      o_addr_ff  <= o_addr_in;
      o_blue_ff  <= o_blue_in;
      o_green_ff <= o_green_in;
      o_red_ff   <= o_red_in;
      o_alpha_ff <= o_alpha_in;
      o_disc_ff  <= o_disc_in;
   end

   // Response channel.
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.write_enable    = o_we_ff;
   assign rsp_bus.byte_address    = o_addr_ff;
   assign rsp_bus.out_byte0_blue  = o_blue_ff;
   assign rsp_bus.out_byte1_green = o_green_ff;
   assign rsp_bus.out_byte2_red   = o_red_ff;
   assign rsp_bus.out_byte3_alpha = o_alpha_ff;
   assign rsp_bus.was_discarded   = o_disc_ff;

endmodule
